// ===== sv/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared constants, types and helpers of the tricubic grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

  localparam int GRID_DIM        = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int COORD_FRAC_BITS = 8;
  localparam int COORD_BITS      = 16;

  localparam int IDX_W      = $clog2(GRID_DIM);
  localparam int SIZE_W     = 6;
  localparam int BANKS      = 4;
  localparam int BANK_W     = $clog2(BANKS);
  localparam int BANK_DEPTH = (GRID_DIM * GRID_DIM * GRID_DIM) / BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Integer part of a coordinate and the neighborhood index range around it.
  localparam int BASE_W = COORD_BITS - COORD_FRAC_BITS;
  localparam int NIDX_W = BASE_W + 2;

  // Weight arithmetic: numerators at 3*F fraction bits (plus the halving),
  // rounded to nearest at 16 fraction bits.
  localparam int W_FRAC  = 16;
  localparam int W_BITS  = 18;
  localparam int N_W     = 3 * COORD_FRAC_BITS + 5;
  localparam int W_SHIFT = 3 * COORD_FRAC_BITS + 1 - W_FRAC;

  localparam int WJK_BITS  = 2 * W_BITS;
  localparam int P_BITS    = WJK_BITS + W_BITS;
  localparam int PROD_BITS = P_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int SUM_FRAC  = 3 * W_FRAC;
  localparam int RES_W     = ACC_BITS - SUM_FRAC;

  localparam int CNT_W = 4;

  // Register map (word index within the configuration space).
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COORD_FRAC_BITS-1:0] frac_t;
  typedef logic signed [W_BITS-1:0]   wgt_t;
  typedef wgt_t [3:0]                 axis_w_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef idx_t [3:0]                 axis_idx_t;
  typedef logic [SAMPLE_BITS-1:0]     sample_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGT,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  // Last usable index along an axis; zero acts as one, oversize as full grid.
  function automatic idx_t size_lim(logic [SIZE_W-1:0] s);
    idx_t r;
    if (s == '0) begin
      r = '0;
    end else if (s > SIZE_W'(GRID_DIM)) begin
      r = idx_t'(GRID_DIM - 1);
    end else begin
      r = idx_t'(s - 1'b1);
    end
    return r;
  endfunction

  function automatic idx_t edge_clamp(logic signed [NIDX_W-1:0] v, idx_t lim);
    idx_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = idx_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/tgi_ram.sv =====
// ----------------------------------------------------------------------------
// tgi_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/tgi_weights.sv =====
// ----------------------------------------------------------------------------
// tgi_weights
// Three-stage pipeline that turns the three coordinate fractions into
// Catmull-Rom weights with 16 fraction bits.
// ----------------------------------------------------------------------------
module tgi_weights (
  input  logic                        clk,
  input  tgi_pkg::frac_t   [2:0]      frac,
  output tgi_pkg::axis_w_t [2:0]      wts
);

  localparam int F  = tgi_pkg::COORD_FRAC_BITS;
  localparam int NW = tgi_pkg::N_W;

  logic [F-1:0]   f1 [3];
  logic [2*F-1:0] sq1 [3];
  logic [2*F-1:0] sq2 [3];
  logic [3*F-1:0] cu2 [3];
  logic [F-1:0]   f2 [3];
  tgi_pkg::axis_w_t [2:0] w_next;

  // Square, then cube.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      f1[a]  <= frac[a];
      sq1[a] <= frac[a] * frac[a];
      f2[a]  <= f1[a];
      sq2[a] <= sq1[a];
      cu2[a] <= sq1[a] * f1[a];
    end
  end

  always_comb begin
    logic signed [NW-1:0] fs, sq, cu;
    logic signed [NW-1:0] n [4];
    for (int a = 0; a < 3; a++) begin
      fs = $signed(NW'(f2[a]));
      sq = $signed(NW'(sq2[a]));
      cu = $signed(NW'(cu2[a]));
      n[0] = -cu + (sq <<< (F + 1)) - (fs <<< (2 * F));
      n[1] = NW'(3) * cu - NW'(5) * (sq <<< F) + (NW'(1) <<< (3 * F + 1));
      n[2] = -(NW'(3) * cu) + NW'(4) * (sq <<< F) + (fs <<< (2 * F));
      n[3] = cu - (sq <<< F);
      for (int i = 0; i < 4; i++) begin
        // Round to nearest, halves up.
        w_next[a][i] = tgi_pkg::wgt_t'(
          (n[i] + (NW'(1) <<< (tgi_pkg::W_SHIFT - 1))) >>> tgi_pkg::W_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    wts <= w_next;
  end

endmodule

// ===== sv/tgi_mac.sv =====
// ----------------------------------------------------------------------------
// tgi_mac
// Weight-product and accumulate pipeline: four neighborhood samples per
// issue, summed exactly into a wide accumulator.
// ----------------------------------------------------------------------------
module tgi_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tgi_pkg::mac_ctl_t                        ctl,
  input  tgi_pkg::wgt_t                            wz,
  input  tgi_pkg::wgt_t                            wy,
  input  tgi_pkg::axis_w_t                         wx,
  input  logic [3:0][tgi_pkg::BANK_W-1:0]          lane_bank,
  input  tgi_pkg::sample_t [tgi_pkg::BANKS-1:0]    bank_rdata,
  output tgi_pkg::acc_t                            acc,
  output logic                                     busy
);

  localparam int WJK  = tgi_pkg::WJK_BITS;
  localparam int PB   = tgi_pkg::P_BITS;
  localparam int PRB  = tgi_pkg::PROD_BITS;
  localparam int ACCB = tgi_pkg::ACC_BITS;

  logic v1, v2, v3, v4;
  logic signed [WJK-1:0] wjk;
  logic signed [PB-1:0]  p [4];
  logic signed [tgi_pkg::SAMPLE_BITS-1:0] smp [4];
  logic signed [PRB-1:0] prod [4];
  logic signed [ACCB-1:0] pair0, pair1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage data: y*z weight alongside the RAM read, then x weight, then sample.
  always_ff @(posedge clk) begin
    wjk <= wz * wy;
    for (int i = 0; i < 4; i++) begin
      p[i]    <= wjk * wx[i];
      smp[i]  <= $signed(bank_rdata[lane_bank[i]]);
      prod[i] <= p[i] * smp[i];
    end
    pair0 <= ACCB'(prod[0]) + ACCB'(prod[1]);
    pair1 <= ACCB'(prod[2]) + ACCB'(prod[3]);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (v4) begin
      acc <= acc + pair0 + pair1;
    end
  end

  assign busy = v1 | v2 | v3 | v4;

endmodule

// ===== sv/tricubic_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// tricubic_grid_interpolator
// Tricubic Catmull-Rom interpolation over a 32x32x32 grid of signed samples
// held in four x-interleaved RAM banks.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | into      | in_valid / in_stall      | operation, write_*, sample_value, query_*
//   out     | out of    | out_valid / out_stall    | interpolated, saturated
//   cfg     | into      | APB psel/penable/pready  | size_x, size_y, size_z
//
// A write transfer stores its sample in the accept cycle.
// A query runs weight setup, then the reads (one x-row of four samples per
// cycle, one from each bank), then drains the multiply and accumulate
// pipeline and loads the output.
// The read rate is set by the four RAM banks, one read port each.
// Reset restores the size registers to 32; grid contents are undefined until
// written. A stalled result holds in the output register while the next item
// is taken; a finished query waits for that register to free up.
//
module tricubic_grid_interpolator (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [4:0]  write_x,
  input  logic [4:0]  write_y,
  input  logic [4:0]  write_z,
  input  logic signed [15:0] sample_value,
  input  logic signed [15:0] query_x,
  input  logic signed [15:0] query_y,
  input  logic signed [15:0] query_z,

  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] interpolated,
  output logic        saturated,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW  = tgi_pkg::SIZE_W;
  localparam int FB  = tgi_pkg::COORD_FRAC_BITS;
  localparam int NW  = tgi_pkg::NIDX_W;
  localparam int BW  = tgi_pkg::BANK_W;
  localparam int IW  = tgi_pkg::IDX_W;
  localparam int RW  = tgi_pkg::RES_W;
  localparam int SB  = tgi_pkg::SAMPLE_BITS;

  // ---------------- configuration registers ----------------
  logic [SW-1:0] size_x, size_y, size_z;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SW'(tgi_pkg::GRID_DIM);
      size_y <= SW'(tgi_pkg::GRID_DIM);
      size_z <= SW'(tgi_pkg::GRID_DIM);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tgi_pkg::REG_SIZE_X: size_x <= pwdata[SW-1:0];
        tgi_pkg::REG_SIZE_Y: size_y <= pwdata[SW-1:0];
        tgi_pkg::REG_SIZE_Z: size_z <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tgi_pkg::REG_SIZE_X: prdata = 32'(size_x);
      tgi_pkg::REG_SIZE_Y: prdata = 32'(size_y);
      tgi_pkg::REG_SIZE_Z: prdata = 32'(size_z);
      default:             prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  tgi_pkg::state_t state, state_next;
  logic [tgi_pkg::CNT_W-1:0] cnt, cnt_next;
  logic in_xfer, out_free, mac_busy;

  assign in_stall = (state != tgi_pkg::ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      tgi_pkg::ST_IDLE:
        if (in_xfer && operation == tgi_pkg::OP_QUERY) state_next = tgi_pkg::ST_WGT;
      tgi_pkg::ST_WGT:
        if (cnt == tgi_pkg::CNT_W'(2)) state_next = tgi_pkg::ST_RUN;
      tgi_pkg::ST_RUN:
        if (&cnt) state_next = tgi_pkg::ST_DRAIN;
      tgi_pkg::ST_DRAIN:
        if (!mac_busy) state_next = tgi_pkg::ST_FIN;
      tgi_pkg::ST_FIN:
        if (out_free) state_next = tgi_pkg::ST_IDLE;
      default: state_next = tgi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_next = '0;
    unique case (state)
      tgi_pkg::ST_WGT: cnt_next = (cnt == tgi_pkg::CNT_W'(2)) ? '0 : cnt + 1'b1;
      tgi_pkg::ST_RUN: cnt_next = cnt + 1'b1;
      default:         cnt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgi_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // ---------------- query capture ----------------
  // Split each coordinate, clamp the four neighborhood indices per axis.
  tgi_pkg::frac_t    [2:0] frac;
  tgi_pkg::axis_idx_t      xi, yi, zi;
  tgi_pkg::axis_idx_t      xi_next, yi_next, zi_next;

  always_comb begin
    logic signed [NW-1:0] bx, by, bz;
    bx = NW'($signed(query_x[15:FB]));
    by = NW'($signed(query_y[15:FB]));
    bz = NW'($signed(query_z[15:FB]));
    for (int i = 0; i < 4; i++) begin
      xi_next[i] = tgi_pkg::edge_clamp(bx - NW'(1) + NW'(i), tgi_pkg::size_lim(size_x));
      yi_next[i] = tgi_pkg::edge_clamp(by - NW'(1) + NW'(i), tgi_pkg::size_lim(size_y));
      zi_next[i] = tgi_pkg::edge_clamp(bz - NW'(1) + NW'(i), tgi_pkg::size_lim(size_z));
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && operation == tgi_pkg::OP_QUERY) begin
      frac[0] <= query_x[FB-1:0];
      frac[1] <= query_y[FB-1:0];
      frac[2] <= query_z[FB-1:0];
      xi <= xi_next;
      yi <= yi_next;
      zi <= zi_next;
    end
  end

  tgi_pkg::axis_w_t [2:0] wts;

  tgi_weights u_weights (
    .clk  (clk),
    .frac (frac),
    .wts  (wts)
  );

  // ---------------- grid banks ----------------
  // Bank = x mod 4; the four clamped x indices of a row never share a bank
  // unless they are equal.
  logic [tgi_pkg::BANKS-1:0]                 bank_we;
  logic [tgi_pkg::BANKS-1:0][tgi_pkg::BANK_AW-1:0] bank_addr;
  tgi_pkg::sample_t [tgi_pkg::BANKS-1:0]     bank_rdata;
  logic [3:0][BW-1:0]                        lane_bank;
  logic [1:0]                                jsel, ksel;

  assign jsel = cnt[1:0];
  assign ksel = cnt[3:2];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_bank[i] = xi[i][BW-1:0];
    end
    for (int b = 0; b < tgi_pkg::BANKS; b++) begin
      bank_we[b]   = in_xfer && (operation == tgi_pkg::OP_WRITE) &&
                     (write_x[BW-1:0] == BW'(b));
      bank_addr[b] = {write_z, write_y, write_x[IW-1:BW]};
      if (state == tgi_pkg::ST_RUN) begin
        for (int i = 0; i < 4; i++) begin
          if (xi[i][BW-1:0] == BW'(b)) begin
            bank_addr[b] = {zi[ksel], yi[jsel], xi[i][IW-1:BW]};
          end
        end
      end
    end
  end

  for (genvar b = 0; b < tgi_pkg::BANKS; b++) begin : g_bank
    tgi_ram #(
      .WIDTH (SB),
      .DEPTH (tgi_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .addr  (bank_addr[b]),
      .wdata (sample_value),
      .rdata (bank_rdata[b])
    );
  end

  // ---------------- multiply and accumulate ----------------
  tgi_pkg::mac_ctl_t mac_ctl;
  tgi_pkg::acc_t     acc;

  assign mac_ctl.issue = (state == tgi_pkg::ST_RUN);
  assign mac_ctl.clear = in_xfer && (operation == tgi_pkg::OP_QUERY);

  tgi_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .wz         (wts[2][ksel]),
    .wy         (wts[1][jsel]),
    .wx         (wts[0]),
    .lane_bank  (lane_bank),
    .bank_rdata (bank_rdata),
    .acc        (acc),
    .busy       (mac_busy)
  );

  // ---------------- round, saturate, output register ----------------
  tgi_pkg::acc_t          rnd;
  logic signed [RW-1:0]   res;
  logic signed [SB-1:0]   res_sat;
  logic                   res_flag;

  always_comb begin
    rnd = acc + (tgi_pkg::acc_t'(1) <<< (tgi_pkg::SUM_FRAC - 1));
    res = rnd[tgi_pkg::ACC_BITS-1:tgi_pkg::SUM_FRAC];
    res_flag = 1'b0;
    res_sat  = res[SB-1:0];
    if (res > $signed(RW'({1'b0, {(SB-1){1'b1}}}))) begin
      res_sat  = {1'b0, {(SB-1){1'b1}}};
      res_flag = 1'b1;
    end else if (res < -$signed(RW'({1'b1, {(SB-1){1'b0}}}))) begin
      res_sat  = {1'b1, {(SB-1){1'b0}}};
      res_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tgi_pkg::ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tgi_pkg::ST_FIN && out_free) begin
      interpolated <= res_sat;
      saturated    <= res_flag;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tricubic grid interpolator: a directed table and
// then random traffic over several grid sizes, each result checked against the
// table or an in-bench tricubic predictor; bursty input, random output stalls.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = tgi_pkg::OP_WRITE;
  logic [4:0]  write_x = '0;
  logic [4:0]  write_y = '0;
  logic [4:0]  write_z = '0;
  logic signed [15:0] sample_value = '0;
  logic signed [15:0] query_x = '0;
  logic signed [15:0] query_y = '0;
  logic signed [15:0] query_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] interpolated;
  logic        saturated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tricubic_grid_interpolator dut (.*);

  always #4 clk = ~clk;

  typedef struct {
    logic signed [15:0] value;
    logic               sat;
  } interp_res_t;

  // One row of the directed table; typed = 1 means the expected value is given.
  typedef struct {
    logic               op;
    logic [4:0]         wx, wy, wz;
    logic signed [15:0] val, qx, qy, qz;
    bit                 typed;
    logic signed [15:0] exp_val;
    logic               exp_sat;
  } dir_row_t;

  // Shadow of the grid and of the size registers.
  logic signed [15:0] grid_shadow [0:32767];
  logic [5:0]         size_shadow [3];
  interp_res_t        pending_q [$];
  int                 err_cnt = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 1;
  bit                 hold_req = 1'b0;
  bit                 xfer_seen;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int eff_size(logic [5:0] s);
    if (s == 0) return 1;
    if (s > tgi_pkg::GRID_DIM) return tgi_pkg::GRID_DIM;
    return int'(s);
  endfunction

  function automatic int clamp_axis(int i, int n);
    if (i < 0) return 0;
    if (i > n - 1) return n - 1;
    return i;
  endfunction

  // Catmull-Rom weights at 16 fraction bits; numerators are at 24 bits plus
  // the halving, so round off 9 bits with halves toward plus infinity.
  function automatic void cr_weights(input longint f, output longint w [4]);
    longint s, f2, f3;
    longint n [4];
    s  = 256;
    f2 = f * f;
    f3 = f2 * f;
    n[0] = -f3 + 2 * f2 * s - f * s * s;
    n[1] = 3 * f3 - 5 * f2 * s + 2 * s * s * s;
    n[2] = -3 * f3 + 4 * f2 * s + f * s * s;
    n[3] = f3 - f2 * s;
    for (int i = 0; i < 4; i++) w[i] = (n[i] + 256) >>> 9;
  endfunction

  function automatic interp_res_t tricubic_value(logic signed [15:0] qx,
                                                 logic signed [15:0] qy,
                                                 logic signed [15:0] qz);
    interp_res_t        res;
    longint             wx [4], wy [4], wz [4];
    int                 bx, by, bz, xi, yi, zi;
    logic signed [127:0] acc, pw, sw, r;
    bx = int'(qx) >>> 8;
    by = int'(qy) >>> 8;
    bz = int'(qz) >>> 8;
    cr_weights(longint'(qx[7:0]), wx);
    cr_weights(longint'(qy[7:0]), wy);
    cr_weights(longint'(qz[7:0]), wz);
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      zi = clamp_axis(bz - 1 + k, eff_size(size_shadow[2]));
      for (int j = 0; j < 4; j++) begin
        yi = clamp_axis(by - 1 + j, eff_size(size_shadow[1]));
        for (int i = 0; i < 4; i++) begin
          xi = clamp_axis(bx - 1 + i, eff_size(size_shadow[0]));
          pw = wz[k] * wy[j] * wx[i];
          sw = grid_shadow[xi + 32 * (yi + 32 * zi)];
          acc = acc + pw * sw;
        end
      end
    end
    acc = acc + (128'sd1 <<< 47);
    r = acc >>> 48;
    res.sat = 1'b0;
    if (r > 32767) begin
      r = 32767;
      res.sat = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      res.sat = 1'b1;
    end
    res.value = r[15:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, wait for the transfer.
  // --------------------------------------------------------------------------
  task automatic send_item(logic op, logic [4:0] wx, wy, wz,
                           logic signed [15:0] val, qx, qy, qz,
                           bit typed = 0, interp_res_t typed_res = '{0, 0});
    @(negedge clk);
    in_valid     = 1'b1;
    operation    = op;
    write_x      = wx;
    write_y      = wy;
    write_z      = wz;
    sample_value = val;
    query_x      = qx;
    query_y      = qy;
    query_z      = qz;
    do @(posedge clk); while (in_stall);
    // Transfer taken: update the shadow and queue what it must produce.
    if (op == tgi_pkg::OP_WRITE) begin
      grid_shadow[int'(wx) + 32 * (int'(wy) + 32 * int'(wz))] = val;
    end else if (typed) begin
      pending_q.push_back(typed_res);
    end else begin
      pending_q.push_back(tricubic_value(qx, qy, qz));
    end
  endtask

  task automatic drop_valid(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Bursts of random length with random gaps between them.
  task automatic pace(int max_gap);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (max_gap > 0) drop_valid($urandom_range(1, max_gap));
    end
  endtask

  // Hold until every expected result is back, then let the block settle.
  task automatic wait_drained();
    drop_valid(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    size_shadow[reg_idx] = data[5:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load the box [0, n) on each axis so every query in this setting only
  // reads written entries.
  task automatic load_box(int nx, int ny, int nz);
    for (int z = 0; z < nz; z++)
      for (int y = 0; y < ny; y++)
        for (int x = 0; x < nx; x++) begin
          send_item(tgi_pkg::OP_WRITE, 5'(x), 5'(y), 5'(z), rand_sample(),
                    16'($urandom), 16'($urandom), 16'($urandom));
          pace(4);
        end
  endtask

  // Coordinate whose neighborhood stays inside the loaded box of size b.
  function automatic logic signed [15:0] rand_coord(int n, int b);
    int hi;
    if (n <= b) begin
      case ($urandom_range(0, 3))
        0: return 16'($urandom);
        1: begin
          case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
          endcase
        end
        default: return 16'($urandom_range(0, n * 256 + 512)) - 16'sd512;
      endcase
    end
    // Largest base that keeps base+2 below b.
    hi = (b - 2) * 256 - 1;
    case ($urandom_range(0, 3))
      0:       return 16'sh8000 | 16'($urandom);
      1:       return 16'($urandom_range(0, hi + 1024)) - 16'sd1024;
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  dir_row_t dir_tab [] = '{
    '{tgi_pkg::OP_WRITE, 5'd0, 5'd0, 5'd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd1, 5'd0, 5'd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    // On a grid point every weight but the center one is exactly zero.
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, S_MAX, 1'b0},
    // Far below the grid: every index clamps to the corner.
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, S_MIN, S_MIN, S_MIN, 1, S_MAX, 1'b0},
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 1, S_MIN, 1'b0},
    // Corner write with junk query fields, which the write ignores.
    '{tgi_pkg::OP_WRITE, 5'd31, 5'd31, 5'd31, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
      0, 16'sd0, 1'b0},
    // A low, high, high, low row along x drives the half-point overshoot past full scale.
    '{tgi_pkg::OP_WRITE, 5'd0, 5'd0, 5'd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd1, 5'd0, 5'd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd2, 5'd0, 5'd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd3, 5'd0, 5'd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sd384, 16'sd0, 16'sd0,
      1, S_MAX, 1'b1},
    // Same query, write fields all ones: they are ignored.
    '{tgi_pkg::OP_QUERY, 5'd31, 5'd31, 5'd31, -16'sd1, 16'sd384, 16'sd0, 16'sd0,
      1, S_MAX, 1'b1},
    '{tgi_pkg::OP_WRITE, 5'd0, 5'd0, 5'd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd1, 5'd0, 5'd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd2, 5'd0, 5'd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_WRITE, 5'd3, 5'd0, 5'd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sd384, 16'sd0, 16'sd0,
      1, S_MIN, 1'b1},
    // Fraction extremes and negative coordinates, left to the predictor.
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sh00FF, 16'sh0080, 16'sh0001,
      0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, -16'sd1, -16'sd256, -16'sd129,
      0, 16'sd0, 1'b0},
    '{tgi_pkg::OP_QUERY, 5'd0, 5'd0, 5'd0, 16'sd0, 16'sd1023, 16'sd1023, 16'sd1023,
      0, 16'sd0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int cfg_tab [6][3];
    int n [3];
    int b [3];
    int max_gap;
    cfg_tab = '{'{32, 32, 32}, '{1, 1, 1}, '{0, 63, 5},
                '{6, 2, 32}, '{0, 0, 0}, '{32, 32, 32}};
    for (int a = 0; a < 3; a++) size_shadow[a] = 6'd32;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset sizes of 32: load a small corner and walk the table.
    load_box(6, 6, 6);
    foreach (dir_tab[r]) begin
      send_item(dir_tab[r].op, dir_tab[r].wx, dir_tab[r].wy, dir_tab[r].wz,
                dir_tab[r].val, dir_tab[r].qx, dir_tab[r].qy, dir_tab[r].qz,
                dir_tab[r].typed, '{dir_tab[r].exp_val, dir_tab[r].exp_sat});
      pace(3);
    end

    for (int ph = 0; ph < 6; ph++) begin
      // Sender pauses here until every result is back; then reconfigure.
      wait_drained();
      for (int a = 0; a < 3; a++) begin
        if (ph == 4) cfg_tab[ph][a] = $urandom_range(0, 63);
        apb_write(2'(a), 32'(cfg_tab[ph][a]) | ({$urandom} & 32'hFFFF_FFC0));
        n[a] = eff_size(size_shadow[a]);
        b[a] = (n[a] < 6) ? n[a] : 6;
      end
      load_box(b[0], b[1], b[2]);
      max_gap = (ph % 2 == 0) ? 6 : 20;
      // Long hold-off on the output while input keeps coming.
      if (ph == 2) hold_req = 1'b1;
      for (int it = 0; it < 140; it++) begin
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(tgi_pkg::OP_WRITE, 5'($urandom_range(0, b[0] - 1)),
                      5'($urandom_range(0, b[1] - 1)), 5'($urandom_range(0, b[2] - 1)),
                      rand_sample(), 16'($urandom), 16'($urandom), 16'($urandom));
          end else begin
            send_item(tgi_pkg::OP_WRITE, 5'($urandom), 5'($urandom), 5'($urandom),
                      rand_sample(), 16'($urandom), 16'($urandom), 16'($urandom));
          end
        end else begin
          send_item(tgi_pkg::OP_QUERY, 5'($urandom), 5'($urandom), 5'($urandom),
                    16'($urandom), rand_coord(n[0], b[0]), rand_coord(n[1], b[1]),
                    rand_coord(n[2], b[2]));
        end
        pace((it < 60) ? 0 : max_gap);
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall on a pattern of its own, plus one long hold-off.
  // --------------------------------------------------------------------------
  initial begin
    int hold_cnt;
    int stall_pct;
    int seg;
    hold_cnt  = 0;
    stall_pct = 0;
    seg       = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 600;
      end
      if (seg == 0) begin
        seg = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      seg--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    interp_res_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: actual %0d sat %0b", $time,
                 interpolated, saturated);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (interpolated !== exp_r.value) begin
          $display("%0t: interpolated mismatch: expected %0d actual %0d", $time,
                   exp_r.value, interpolated);
          err_cnt++;
        end
        if (saturated !== exp_r.sat) begin
          $display("%0t: saturated mismatch: expected %0b actual %0b", $time,
                   exp_r.sat, saturated);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    xfer_seen = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable);
    if (rst || xfer_seen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
sv/tgi_pkg.sv
sv/tgi_ram.sv
sv/tgi_weights.sv
sv/tgi_mac.sv
sv/tricubic_grid_interpolator.sv
bench/tb.sv
